// ----- hdl/gdbt_pkg.sv -----
package gdbt_pkg;

  localparam int unsigned NumVertices = 64;
  localparam int unsigned VertexWidth = $clog2(NumVertices);
  localparam int unsigned CountWidth  = VertexWidth + 1;

  localparam logic [1:0] OpAddEdge = 2'd0;
  localparam logic [1:0] OpRemove  = 2'd1;
  localparam logic [1:0] OpDfs     = 2'd2;
  localparam logic [1:0] OpBfs     = 2'd3;

  localparam logic [6:0] CountReset = 7'd64;

  function automatic logic [VertexWidth-1:0] lowest_set(input logic [NumVertices-1:0] x);
    logic [VertexWidth-1:0] r;
    r = '0;
    for (int i = NumVertices - 1; i >= 0; i--) begin
      if (x[i]) begin
        r = VertexWidth'(i);
      end
    end
    return r;
  endfunction

endpackage

// ----- hdl/gdbt_ram.sv -----
module gdbt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hdl/graph_dfs_bfs_traversal_top.sv -----
// add edge: rows A and B are each read, then written; remove vertex: a read-modify-write
// pass over all 64 rows (row and column); traversal: an adjacency row is read once per
// vertex breadth-first and twice depth-first (push and pop); one item at a time
// reset: adjacency memory is cleared by a pass over all 64 rows after reset; no item is
// taken during it, configuration writes are taken; vertex_count resets to 64
module graph_dfs_bfs_traversal_top
  import gdbt_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [0:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             operation_i,
  input  logic [VertexWidth-1:0] first_vertex_i,
  input  logic [VertexWidth-1:0] second_vertex_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [VertexWidth-1:0] visited_vertex_o,
  output logic                   last_o
);

  typedef enum logic [3:0] {
    StClear, StIdle, StRdA, StWrA, StRdB, StWrB, StRmCol, StRmWr,
    StStart, StRead, StWait, StStep, StEmit
  } state_e;

  state_e state_q;
  logic [6:0] vcount_q;
  logic [NumVertices-1:0] removed_q, visited_q, cand_q;
  logic [1:0] op_q;
  logic [VertexWidth-1:0] a_q, b_q, s_q, w_q;
  logic [CountWidth-1:0] head_q, tail_q, idx_q;
  logic s_done_q;
  logic pend_q;
  logic [VertexWidth-1:0] pend_v_q;
  logic out_valid_q, out_last_q;
  logic [VertexWidth-1:0] out_v_q;

  logic adj_we;
  logic [VertexWidth-1:0] adj_waddr, adj_raddr;
  logic [NumVertices-1:0] adj_wdata, adj_rdata;
  logic st_we;
  logic [VertexWidth-1:0] st_waddr, st_raddr, st_rdata;

  gdbt_ram #(.Width(NumVertices), .Depth(NumVertices)) u_adj (
    .clk_i, .we_i(adj_we), .waddr_i(adj_waddr), .wdata_i(adj_wdata),
    .raddr_i(adj_raddr), .rdata_o(adj_rdata)
  );

  gdbt_ram #(.Width(VertexWidth), .Depth(NumVertices)) u_store (
    .clk_i, .we_i(st_we), .waddr_i(st_waddr), .wdata_i(w_q),
    .raddr_i(st_raddr), .rdata_o(st_rdata)
  );

  logic [CountWidth-1:0] n_eff;
  logic [NumVertices-1:0] live, cand_now, unv;
  logic out_free;
  logic emit_go, end_go, out_load;

  always_comb begin
    n_eff = (vcount_q > 7'(NumVertices)) ? CountWidth'(NumVertices)
                                         : CountWidth'(vcount_q);
    for (int i = 0; i < NumVertices; i++) begin
      live[i] = (CountWidth'(i) < n_eff);
    end
    cand_now = adj_rdata & ~visited_q;
    unv = ~visited_q;
    out_free = !out_valid_q || !out_stall_i;
    emit_go = (state_q == StEmit) && (!pend_q || out_free);
    end_go = (state_q == StStart) && (s_done_q || !unv[s_q])
             && (s_done_q || s_q == VertexWidth'(NumVertices - 1)) && out_free;
    out_load = (emit_go || end_go) && pend_q;
  end

  assign pready = 1'b1;
  assign prdata = {25'd0, vcount_q};
  assign in_stall_o = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign visited_vertex_o = out_v_q;
  assign last_o = out_last_q;

  always_comb begin
    adj_we = 1'b0;
    adj_waddr = idx_q[VertexWidth-1:0];
    adj_wdata = '0;
    adj_raddr = idx_q[VertexWidth-1:0];
    st_we = 1'b0;
    st_waddr = tail_q[VertexWidth-1:0];
    st_raddr = (op_q == OpDfs) ? VertexWidth'(tail_q - 1'b1) : head_q[VertexWidth-1:0];
    case (state_q)
      StClear: begin
        adj_we = 1'b1;
      end
      StIdle, StRdA: adj_raddr = a_q;
      StRdB: adj_raddr = b_q;
      StWrA: begin
        adj_we = 1'b1;
        adj_waddr = a_q;
        adj_wdata = adj_rdata | (NumVertices'(1) << b_q);
      end
      StWrB: begin
        adj_we = 1'b1;
        adj_waddr = b_q;
        adj_wdata = adj_rdata | (NumVertices'(1) << a_q);
      end
      StRmWr: begin
        adj_we = 1'b1;
        adj_waddr = idx_q[VertexWidth-1:0];
        adj_wdata = (idx_q[VertexWidth-1:0] == a_q) ? '0
                    : adj_rdata & ~(NumVertices'(1) << a_q);
      end
      StWait: adj_raddr = st_rdata;
      StEmit: st_we = emit_go && (tail_q < CountWidth'(NumVertices));
      default: ;
    endcase
    if (state_q == StStep || state_q == StEmit) begin
      st_waddr = tail_q[VertexWidth-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      vcount_q <= CountReset;
      removed_q <= '0;
      visited_q <= '0;
      idx_q <= '0;
      head_q <= '0;
      tail_q <= '0;
      out_valid_q <= 1'b0;
      pend_q <= 1'b0;
      s_done_q <= 1'b0;
    end else begin
      if (psel && penable && pwrite && paddr == 1'b0) begin
        vcount_q <= pwdata[6:0];
      end
      if (out_valid_q && !out_stall_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StClear: begin
          idx_q <= idx_q + 1'b1;
          if (idx_q == CountWidth'(NumVertices - 1)) begin
            state_q <= StIdle;
          end
        end
        StIdle: begin
          if (in_valid_i) begin
            op_q <= operation_i;
            a_q <= first_vertex_i;
            b_q <= second_vertex_i;
            idx_q <= '0;
            case (operation_i)
              OpAddEdge: state_q <= StRdA;
              OpRemove: begin
                removed_q[first_vertex_i] <= 1'b1;
                state_q <= StRmCol;
              end
              default: begin
                visited_q <= removed_q | ~live;
                s_q <= '0;
                s_done_q <= 1'b0;
                state_q <= StStart;
              end
            endcase
          end
        end
        StRdA: state_q <= StWrA;
        StWrA: state_q <= StRdB;
        StRdB: state_q <= StWrB;
        StWrB: state_q <= StIdle;
        StRmCol: state_q <= StRmWr;
        StRmWr: begin
          idx_q <= idx_q + 1'b1;
          state_q <= (idx_q == CountWidth'(NumVertices - 1)) ? StIdle : StRmCol;
        end
        StStart: begin
          if (s_done_q || !unv[s_q]) begin
            if (s_done_q || s_q == VertexWidth'(NumVertices - 1)) begin
              if (out_free) begin
                state_q <= StIdle;
                if (pend_q) begin
                  out_valid_q <= 1'b1;
                  out_v_q <= pend_v_q;
                  out_last_q <= 1'b1;
                  pend_q <= 1'b0;
                end
              end
            end else begin
              s_q <= s_q + 1'b1;
            end
          end else begin
            w_q <= s_q;
            visited_q[s_q] <= 1'b1;
            head_q <= '0;
            tail_q <= '0;
            state_q <= StEmit;
          end
        end
        StEmit: begin
          if (emit_go) begin
            if (pend_q) begin
              out_valid_q <= 1'b1;
              out_v_q <= pend_v_q;
              out_last_q <= 1'b0;
            end
            pend_q <= 1'b1;
            pend_v_q <= w_q;
            if (tail_q < CountWidth'(NumVertices)) begin
              tail_q <= tail_q + 1'b1;
            end
            state_q <= (op_q == OpBfs && idx_q != '0) ? StStep : StRead;
          end
        end
        StRead: begin
          if (op_q == OpDfs ? tail_q == '0 : head_q == tail_q) begin
            if (s_q == VertexWidth'(NumVertices - 1)) begin
              s_done_q <= 1'b1;
            end else begin
              s_q <= s_q + 1'b1;
            end
            state_q <= StStart;
          end else begin
            state_q <= StWait;
          end
        end
        StWait: begin
          state_q <= StStep;
          if (op_q == OpBfs) begin
            head_q <= head_q + 1'b1;
          end
          idx_q <= '0;
        end
        StStep: begin
          if (idx_q == '0) begin
            cand_q <= cand_now & ~removed_q;
            idx_q <= CountWidth'(1);
          end else if (cand_q == '0) begin
            if (op_q == OpDfs) begin
              tail_q <= tail_q - 1'b1;
            end
            state_q <= StRead;
          end else begin
            w_q <= lowest_set(cand_q);
            visited_q[lowest_set(cand_q)] <= 1'b1;
            if (op_q == OpDfs) begin
              state_q <= StEmit;
            end else begin
              cand_q[lowest_set(cand_q)] <= 1'b0;
              state_q <= StEmit;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule
